// ----- hw/rtl/hsl_to_rgb_converter_assert.svh -----
// assertion macros used by the converter top file
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// clocked check, masked while reset is high
`define HSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define HSL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/hsl_pkg.sv -----
package hsl_pkg;

  // fixed point scales
  localparam logic [14:0] HUE_FULL   = 15'd23040;
  localparam logic [14:0] HUE_SEC1   = 15'd3840;
  localparam logic [14:0] HUE_SEC2   = 15'd7680;
  localparam logic [14:0] HUE_SEC3   = 15'd11520;
  localparam logic [14:0] HUE_SEC4   = 15'd15360;
  localparam logic [14:0] HUE_SEC5   = 15'd19200;
  localparam logic [11:0] TRI_FULL   = 12'd3840;
  localparam logic [12:0] FRAC_ONE   = 13'd4096;

  // channel value width, over denominator 2^24 * 3840
  localparam int unsigned VW = 36;

  // hue sectors, red-yellow through magenta-red
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  // chroma, triangle weight and lightness of one word
  typedef struct packed {
    logic [24:0] chroma;
    logic [11:0] weight;
    logic [12:0] lig;
    sector_t     sector;
  } front_t;

  // unscaled channel values
  typedef struct packed {
    logic [VW-1:0] r;
    logic [VW-1:0] g;
    logic [VW-1:0] b;
  } chan_t;

  // final bytes
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

// ----- hw/rtl/hsl_pixel_if.sv -----
interface hsl_pixel_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [12:0] saturation;
  logic [12:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness, input ready);
  modport sink   (input valid, input hue, input saturation, input lightness, output ready);
endinterface

// ----- hw/rtl/hsl_rgb_if.sv -----
interface hsl_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hw/rtl/hsl_front.sv -----
module hsl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [14:0]         hue,
  input  logic [12:0]         saturation,
  input  logic [12:0]         lightness,
  output logic                out_valid,
  input  logic                out_ready,
  output hsl_pkg::front_t     out_data
);

  // stage a registers
  logic                a_valid;
  logic [12:0]         a_sat;
  logic [12:0]         a_lig;
  logic [12:0]         a_span;
  logic [11:0]         a_pos;
  hsl_pkg::sector_t    a_sector;

  // stage b registers
  logic                b_valid;
  hsl_pkg::front_t     b_data;

  logic                a_ready;
  logic                b_ready;

  logic [14:0]         hue_w;
  logic [12:0]         sat_c;
  logic [12:0]         lig_c;
  logic [13:0]         twol;
  logic [13:0]         span14;
  logic [14:0]         base;
  logic [14:0]         pos15;
  hsl_pkg::sector_t    sector;
  logic [25:0]         prod;
  logic                odd;

  // bubbles collapse: a stage takes a word when empty or draining
  assign b_ready  = !b_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // wrap hue, clamp fractions, fold lightness
  always_comb begin
    hue_w  = (hue >= hsl_pkg::HUE_FULL) ? hue - hsl_pkg::HUE_FULL : hue;
    sat_c  = (saturation > hsl_pkg::FRAC_ONE) ? hsl_pkg::FRAC_ONE : saturation;
    lig_c  = (lightness > hsl_pkg::FRAC_ONE) ? hsl_pkg::FRAC_ONE : lightness;
    twol   = {lig_c, 1'b0};
    span14 = (twol >= 14'd4096) ? 14'd8192 - twol : twol;
  end

  // hue sector and position within it
  always_comb begin
    priority if (hue_w >= hsl_pkg::HUE_SEC5) begin
      sector = hsl_pkg::SEC_MR;
      base   = hsl_pkg::HUE_SEC5;
    end else if (hue_w >= hsl_pkg::HUE_SEC4) begin
      sector = hsl_pkg::SEC_BM;
      base   = hsl_pkg::HUE_SEC4;
    end else if (hue_w >= hsl_pkg::HUE_SEC3) begin
      sector = hsl_pkg::SEC_CB;
      base   = hsl_pkg::HUE_SEC3;
    end else if (hue_w >= hsl_pkg::HUE_SEC2) begin
      sector = hsl_pkg::SEC_GC;
      base   = hsl_pkg::HUE_SEC2;
    end else if (hue_w >= hsl_pkg::HUE_SEC1) begin
      sector = hsl_pkg::SEC_YG;
      base   = hsl_pkg::HUE_SEC1;
    end else begin
      sector = hsl_pkg::SEC_RY;
      base   = 15'd0;
    end
    pos15 = hue_w - base;
  end

  // chroma product and triangle weight
  always_comb begin
    prod = 26'(a_span) * 26'(a_sat);
    odd  = (a_sector == hsl_pkg::SEC_YG) || (a_sector == hsl_pkg::SEC_CB) ||
           (a_sector == hsl_pkg::SEC_MR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= in_valid;
      if (b_ready) b_valid <= a_valid;
    end
    if (a_ready && in_valid) begin
      a_sat    <= sat_c;
      a_lig    <= lig_c;
      a_span   <= span14[12:0];
      a_pos    <= pos15[11:0];
      a_sector <= sector;
    end
    if (b_ready && a_valid) begin
      b_data.chroma <= prod[24:0];
      b_data.weight <= odd ? hsl_pkg::TRI_FULL - a_pos : a_pos;
      b_data.lig    <= a_lig;
      b_data.sector <= a_sector;
    end
  end

  assign out_valid = b_valid;
  assign out_data  = b_data;

endmodule

// ----- hw/rtl/hsl_mix.sv -----
module hsl_mix (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  hsl_pkg::front_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hsl_pkg::chan_t   out_data
);

  localparam int unsigned VW = hsl_pkg::VW;

  // stage c registers
  logic                c_valid;
  logic [24:0]         c_m24;
  logic [VW-1:0]       c_x;
  logic [VW-1:0]       c_c;
  hsl_pkg::sector_t    c_sector;

  // stage d registers
  logic                d_valid;
  hsl_pkg::chan_t      d_data;

  logic                c_ready;
  logic                d_ready;

  logic [24:0]         m24;
  logic [36:0]         xprod;
  logic [36:0]         cprod;
  logic [36:0]         mprod;
  logic [VW-1:0]       md;
  logic [VW-1:0]       sel_r;
  logic [VW-1:0]       sel_g;
  logic [VW-1:0]       sel_b;

  assign d_ready  = !d_valid || out_ready;
  assign c_ready  = !c_valid || d_ready;
  assign in_ready = c_ready;

  // offset m and the chroma and x products, times 3840 as shift-subtract
  always_comb begin
    m24   = {in_data.lig, 12'b0} - {1'b0, in_data.chroma[24:1]};
    xprod = 37'(in_data.chroma) * 37'(in_data.weight);
    cprod = 37'({in_data.chroma, 12'b0}) - 37'({in_data.chroma, 8'b0});
  end

  // arrange chroma, x and zero by sector, then add m
  always_comb begin
    mprod = 37'({c_m24, 12'b0}) - 37'({c_m24, 8'b0});
    md    = mprod[VW-1:0];
    unique case (c_sector)
      hsl_pkg::SEC_RY: begin sel_r = c_c; sel_g = c_x; sel_b = '0;  end
      hsl_pkg::SEC_YG: begin sel_r = c_x; sel_g = c_c; sel_b = '0;  end
      hsl_pkg::SEC_GC: begin sel_r = '0;  sel_g = c_c; sel_b = c_x; end
      hsl_pkg::SEC_CB: begin sel_r = '0;  sel_g = c_x; sel_b = c_c; end
      hsl_pkg::SEC_BM: begin sel_r = c_x; sel_g = '0;  sel_b = c_c; end
      default:         begin sel_r = c_c; sel_g = '0;  sel_b = c_x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (c_ready) c_valid <= in_valid;
      if (d_ready) d_valid <= c_valid;
    end
    if (c_ready && in_valid) begin
      c_m24    <= m24;
      c_x      <= xprod[VW-1:0];
      c_c      <= cprod[VW-1:0];
      c_sector <= in_data.sector;
    end
    if (d_ready && c_valid) begin
      d_data.r <= sel_r + md;
      d_data.g <= sel_g + md;
      d_data.b <= sel_b + md;
    end
  end

  assign out_valid = d_valid;
  assign out_data  = d_data;

endmodule

// ----- hw/rtl/hsl_byte.sv -----
module hsl_byte (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  hsl_pkg::chan_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hsl_pkg::rgb_t    out_data
);

  localparam int unsigned VW = hsl_pkg::VW;
  // half of the denominator 2^33 * 15, for round to nearest
  localparam logic [VW+9:0] BIAS  = (VW+10)'(15) << 32;
  // 65535 / 15, reciprocal for the final divide
  localparam logic [26:0]   RECIP = 27'd4369;

  // value * 510 + bias, shifted down by 33
  function automatic logic [12:0] coarse(input logic [VW-1:0] v);
    logic [VW+9:0] w;
    w = (VW+10)'({v, 9'b0}) - (VW+10)'({v, 1'b0}) + BIAS;
    return w[VW+9:33];
  endfunction

  // divide by 15 and saturate to a byte
  function automatic logic [7:0] to_byte(input logic [12:0] t);
    logic [26:0] p;
    p = (27'(t) + 27'd1) * RECIP;
    return (p[26:16] > 11'd255) ? 8'hFF : p[23:16];
  endfunction

  // stage e registers
  logic          e_valid;
  logic [12:0]   e_r;
  logic [12:0]   e_g;
  logic [12:0]   e_b;

  // output registers
  logic          f_valid;
  hsl_pkg::rgb_t f_data;

  logic          e_ready;
  logic          f_ready;

  assign f_ready  = !f_valid || out_ready;
  assign e_ready  = !e_valid || f_ready;
  assign in_ready = e_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      f_valid <= 1'b0;
    end else begin
      if (e_ready) e_valid <= in_valid;
      if (f_ready) f_valid <= e_valid;
    end
    if (e_ready && in_valid) begin
      e_r <= coarse(in_data.r);
      e_g <= coarse(in_data.g);
      e_b <= coarse(in_data.b);
    end
    if (f_ready && e_valid) begin
      f_data.red   <= to_byte(e_r);
      f_data.green <= to_byte(e_g);
      f_data.blue  <= to_byte(e_b);
    end
  end

  assign out_valid = f_valid;
  assign out_data  = f_data;

endmodule

// ----- hw/rtl/hsl_to_rgb_converter.sv -----
// HSL to 8-bit RGB converter. Takes one pixel word per clock and returns one
// RGB word per pixel; while the output side is ready, throughput is one pixel
// per cycle, set by a six-stage pipeline with a valid bit on every stage and
// bubble-collapsing ready. Hue is in 1/64 degree (codes of 360 degrees or more
// wrap once), saturation and lightness are fractions of 4096 and clamp at
// 4096. Channels are exact until the final round to nearest, ties away from
// zero, and saturate to 0..255.
`include "hsl_to_rgb_converter_assert.svh"

module hsl_to_rgb_converter (
  input  logic         clk,
  input  logic         rst,
  hsl_pixel_if.sink    pixel,
  hsl_rgb_if.source    color
);

  localparam int unsigned DEPTH = 6;

  logic             front_valid;
  logic             front_ready;
  hsl_pkg::front_t  front_data;
  logic             mix_valid;
  logic             mix_ready;
  hsl_pkg::chan_t   mix_data;
  hsl_pkg::rgb_t    rgb_data;

  // sector, chroma and triangle weight
  hsl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pixel.valid),
    .in_ready   (pixel.ready),
    .hue        (pixel.hue),
    .saturation (pixel.saturation),
    .lightness  (pixel.lightness),
    .out_valid  (front_valid),
    .out_ready  (front_ready),
    .out_data   (front_data)
  );

  // channel arrangement and offset
  hsl_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (mix_valid),
    .out_ready (mix_ready),
    .out_data  (mix_data)
  );

  // scaling to bytes
  hsl_byte u_byte (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .in_data   (mix_data),
    .out_valid (color.valid),
    .out_ready (color.ready),
    .out_data  (rgb_data)
  );

  assign color.red   = rgb_data.red;
  assign color.green = rgb_data.green;
  assign color.blue  = rgb_data.blue;

  // words in flight, for the checks below
  logic [2:0] inflight;
  logic [2:0] inflight_next;
  logic       acc_in;
  logic       acc_out;

  assign acc_in  = pixel.valid && pixel.ready;
  assign acc_out = color.valid && color.ready;

  always_comb begin
    inflight_next = inflight + 3'(acc_in) - 3'(acc_out);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 3'd0;
    end else begin
      inflight <= inflight_next;
    end
  end

  `HSL_ASSERT_ALWAYS(a_reset_empty, rst |=> !color.valid, "output valid after reset")
  `HSL_ASSERT(a_depth, inflight <= 3'(DEPTH), "more words in flight than stages")
  `HSL_ASSERT(a_empty_quiet, (inflight == 3'd0) |-> !color.valid, "output without input")
  `HSL_ASSERT(a_stall_full, !pixel.ready |-> (color.valid && !color.ready &&
    inflight == 3'(DEPTH)), "input stalled while pipeline not full")

endmodule
